### sv/jmfs_pkg.sv
// Package for the JPEG marker frame sizer: types, marker codes and the per-position check.
`default_nettype none

package jmfs_pkg;

  localparam int unsigned BufBytes = 65536;
  localparam int unsigned PosW     = $clog2(BufBytes);
  localparam int unsigned LenW     = 17;
  localparam int unsigned PadW     = 17;
  localparam int unsigned SizeW    = 18;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned QDepth   = 3;
  localparam int unsigned QCntW    = 2;

  localparam logic [7:0] MarkLead = 8'hFF;
  localparam logic [7:0] MarkSoi  = 8'hD8;
  localparam logic [7:0] MarkEoi  = 8'hD9;
  localparam logic [7:0] PadByte  = 8'h00;

  localparam logic [IdxW-1:0]  IdxMax   = {IdxW{1'b1}};
  localparam logic [IdxW-1:0]  IdxFirst = IdxW'(1);
  localparam logic [PosW-1:0]  PosLast  = PosW'(BufBytes - 1);

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_SUMMARY = 1'b1
  } rec_kind_e;

  typedef struct packed {
    logic [PosW-1:0] start;
    logic [LenW-1:0] len;
    logic            hdr;
    logic            ftr;
    logic [PadW-1:0] pad;
    logic [IdxW-1:0] idx;
  } scan_state_t;

  typedef struct packed {
    scan_state_t st;
    logic        hdr_hit;
  } judge_t;

  typedef struct packed {
    rec_kind_e        kind;
    logic [IdxW-1:0]  idx;
    logic [SizeW-1:0] size;
    logic [PadW-1:0]  pad;
  } record_t;

  localparam scan_state_t StateRst = '{
    start: '0, len: '0, hdr: 1'b0, ftr: 1'b0, pad: '0, idx: IdxFirst
  };

  // Judge one buffer position from its byte and the two that follow it.
  function automatic judge_t judge(scan_state_t s, logic [7:0] b0, logic [7:0] b1,
                                   logic [7:0] b2, logic [PosW-1:0] pos);
    judge_t r;
    r.st      = s;
    r.hdr_hit = 1'b0;
    if (b0 == MarkLead && b1 == MarkSoi) begin
      r.hdr_hit  = 1'b1;
      r.st.ftr   = 1'b0;
      r.st.pad   = '0;
      r.st.start = pos;
      r.st.hdr   = 1'b1;
      if (s.idx != IdxMax) begin
        r.st.idx = s.idx + IdxW'(1);
      end
    end
    if (b0 == MarkLead && b1 == MarkEoi && r.st.hdr) begin
      r.st.len = LenW'({1'b0, pos} - {1'b0, r.st.start} + LenW'(2));
      r.st.ftr = 1'b1;
    end
    if (r.st.ftr && b0 == PadByte && b1 != MarkLead && b2 != MarkSoi) begin
      r.st.pad = r.st.pad + PadW'(1);
    end
    return r;
  endfunction

  function automatic record_t make_rec(rec_kind_e kind, scan_state_t s);
    record_t r;
    r.kind = kind;
    r.idx  = s.idx;
    r.size = SizeW'(s.len) + SizeW'(s.pad);
    r.pad  = s.pad;
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/jpeg_marker_frame_sizer_top.sv
// Top level of the JPEG marker frame sizer: byte scanner and result queue.
//
// Takes one capture-buffer byte per clock and judges each position against the two bytes
// that follow it, so a position is resolved two bytes after it arrives. An FF D8 pair
// yields a header record (tlast low) carrying the image index, the previous image's length
// plus trailing zero padding, and that padding count. The byte flagged by tlast, or the
// 65536th byte, flushes the last two positions and yields a summary record (tlast high),
// after which all counters return to their reset values. Rate: one byte per cycle with no
// gaps as long as the record sink keeps up; the final byte can produce two records, which
// a three-entry result queue absorbs, and s_axis_tready drops only when that queue holds
// three records, or two while the sink is not taking one. Records are written into the
// registered result queue and presented from its head.
`default_nettype none

module jpeg_marker_frame_sizer_top import jmfs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_buffer
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [7:0] image_index, [25:8] image_size,
                                           // [42:26] pad_count, [47:43] zero
  output logic             m_axis_tlast    // record_kind (1: summary, last of run)
);

  scan_state_t     st_q, st_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      w0_q, w1_q;
  record_t         q_q [QDepth];
  record_t         q_d [QDepth];
  logic [QCntW-1:0] qcnt_q, qcnt_d;

  logic    in_acc, out_acc, last;
  judge_t  j1, j2, j3;
  record_t hdr_rec, sum_rec;
  logic    hdr_hit;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign last    = s_axis_tlast || (pos_q == PosLast);

  always_comb begin
    j1 = '{st: st_q, hdr_hit: 1'b0};
    if (pos_q >= PosW'(2)) begin
      j1 = judge(st_q, w0_q, w1_q, s_axis_tdata, pos_q - PosW'(2));
    end
    // Flush positions only exist on the last byte
    j2 = '{st: j1.st, hdr_hit: 1'b0};
    if (pos_q != '0) begin
      j2 = judge(j1.st, w1_q, s_axis_tdata, PadByte, pos_q - PosW'(1));
    end
    j3 = judge(j2.st, s_axis_tdata, PadByte, PadByte, pos_q);
  end

  // A header hit on the first flush position leaves the state untouched beforehand,
  // so the header record always reflects the registered state.
  assign hdr_hit = j1.hdr_hit || (last && j2.hdr_hit);
  assign hdr_rec = make_rec(KIND_HEADER, st_q);
  assign sum_rec = make_rec(KIND_SUMMARY, j3.st);

  always_comb begin
    st_d  = st_q;
    pos_d = pos_q;
    if (in_acc) begin
      if (last) begin
        st_d  = StateRst;
        pos_d = '0;
      end else begin
        st_d  = j1.st;
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StateRst;
      pos_q <= '0;
      w0_q  <= '0;
      w1_q  <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      if (in_acc) begin
        w0_q <= last ? PadByte : w1_q;
        w1_q <= last ? PadByte : s_axis_tdata;
      end
    end
  end

  // Result queue: pop from the head, then append up to two records.
  always_comb begin
    q_d    = q_q;
    qcnt_d = qcnt_q;
    if (out_acc) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        q_d[i] = q_q[i+1];
      end
      qcnt_d = qcnt_d - QCntW'(1);
    end
    if (in_acc && (hdr_hit || last)) begin
      q_d[qcnt_d] = hdr_hit ? hdr_rec : sum_rec;
      qcnt_d      = qcnt_d + QCntW'(1);
    end
    if (in_acc && hdr_hit && last) begin
      q_d[qcnt_d] = sum_rec;
      qcnt_d      = qcnt_d + QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q <= '0;
    end else begin
      qcnt_q <= qcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  // With two records held, a pop in the same cycle leaves room for two more
  assign s_axis_tready = (qcnt_q <= QCntW'(1)) || ((qcnt_q == QCntW'(2)) && m_axis_tready);
  assign m_axis_tvalid = (qcnt_q != '0);
  assign m_axis_tlast  = q_q[0].kind;
  assign m_axis_tdata  = {5'b0, q_q[0].pad, q_q[0].size, q_q[0].idx};

endmodule

`default_nettype wire
